// ----- src/dit_pkg.sv -----
// Package for the disjoint interval tracker: command and status codes.
// No dependencies.
package dit_pkg;
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_COVERED  = 3'd0,
    ST_EXTENDED = 3'd1,
    ST_MERGED   = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4,
    ST_READ     = 3'd5
  } status_t;
endpackage

// ----- src/dit_front.sv -----
// Front end of the interval tracker: takes commands and queues them for the engine.
// Depends on dit_pkg.
module dit_front #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  cmd,
  input  logic [15:0]           value,
  output logic                  busy,
  // queue head toward the engine
  output logic                  q_valid,
  output logic                  q_cmd,
  output logic [VALUE_BITS-1:0] q_value,
  input  logic                  q_pop
);
  import dit_pkg::*;

  // two-word queue: the engine may hold one word while the next one waits
  logic [1:0]            cnt;
  logic                  cmd_q   [2];
  logic [VALUE_BITS-1:0] value_q [2];
  logic                  push;
  logic                  to_head;
  logic [VALUE_BITS-1:0] value_trim;

  assign busy  = (cnt == 2'd2);
  assign push  = start && !busy;
  assign value_trim = VALUE_BITS'(value);

  // new word goes to the head when the head slot is free after this edge
  assign to_head = push && (q_pop ? (cnt == 2'd1) : (cnt == 2'd0));

  assign q_valid = (cnt != 2'd0);
  assign q_cmd   = cmd_q[0];
  assign q_value = value_q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

  // payload shift: slot 0 is the head
  always_ff @(posedge clk) begin
    if (to_head) begin
      cmd_q[0]   <= cmd;
      value_q[0] <= value_trim;
    end else if (q_pop) begin
      cmd_q[0]   <= cmd_q[1];
      value_q[0] <= value_q[1];
    end
    if (push && !to_head) begin
      cmd_q[1]   <= cmd;
      value_q[1] <= value_trim;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
endmodule

// ----- src/dit_engine.sv -----
// Back end of the interval tracker: searches, edits and reads out the table.
// Depends on dit_pkg. Table arrays are memories local to this module.
module dit_engine #(
  parameter int MAX_RANGES = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  logic                  q_cmd,
  input  logic [VALUE_BITS-1:0] q_value,
  output logic                  q_pop,
  output logic                  strobe,
  output dit_pkg::status_t      status,
  output logic [15:0]           range_low,
  output logic [15:0]           range_high,
  output logic                  is_empty,
  output logic                  last
);
  import dit_pkg::*;

  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHUP, S_PLACE, S_SHDN, S_READ
  } state_t;

  // table memories: one read and one write port each, registered read
  logic [VALUE_BITS-1:0] lo_mem [MAX_RANGES];
  logic [VALUE_BITS-1:0] hi_mem [MAX_RANGES];
  logic [VALUE_BITS-1:0] lo_rd, hi_rd;
  logic [IW-1:0]         rd_addr;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_lo, wr_hi;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         idx, idx_next;          // entry now in lo_rd/hi_rd (shift, read)
  logic [CW-1:0]         pos, pos_next;          // first entry with lower end above v
  logic [VALUE_BITS-1:0] v, v_next;
  logic [VALUE_BITS-1:0] left_lo, left_lo_next;  // entry pos-1
  logic [VALUE_BITS-1:0] prev_hi, prev_hi_next;
  logic [VALUE_BITS-1:0] next_lo, next_lo_next;  // entry pos
  logic [VALUE_BITS-1:0] next_hi, next_hi_next;
  logic                  strobe_next, is_empty_next, last_next;
  status_t               status_next;
  logic [15:0]           range_low_next, range_high_next;

  always_ff @(posedge clk) begin
    lo_rd <= lo_mem[rd_addr];
    hi_rd <= hi_mem[rd_addr];
    if (wr_en) begin
      lo_mem[wr_addr] <= wr_lo;
      hi_mem[wr_addr] <= wr_hi;
    end
  end

  // wide compares on v against neighbors
  logic has_left, has_right, left_adj, right_adj, covered;
  logic [VALUE_BITS:0] prev_hi_p1, v_p1;
  assign prev_hi_p1 = {1'b0, prev_hi} + 1'b1;
  assign v_p1       = {1'b0, v} + 1'b1;
  assign has_left   = (pos != '0);
  assign has_right  = (pos < count);
  assign covered    = has_left && (v <= prev_hi);
  assign left_adj   = has_left && (prev_hi_p1 == {1'b0, v});
  assign right_adj  = has_right && (v_p1 == {1'b0, next_lo});

  // sequencer next state, memory control and result word
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    pos_next        = pos;
    v_next          = v;
    left_lo_next    = left_lo;
    prev_hi_next    = prev_hi;
    next_lo_next    = next_lo;
    next_hi_next    = next_hi;
    // add results carry zero ranges and last set
    strobe_next     = 1'b0;
    status_next     = status;
    range_low_next  = '0;
    range_high_next = '0;
    is_empty_next   = 1'b0;
    last_next       = 1'b1;
    rd_addr         = idx[IW-1:0];
    wr_en           = 1'b0;
    wr_addr         = pos[IW-1:0];
    wr_lo           = v;
    wr_hi           = v;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          v_next   = q_value;
          pos_next = '0;
          idx_next = '0;
          rd_addr  = '0;
          if (q_cmd == CMD_READ) begin
            if (count == '0) begin
              strobe_next   = 1'b1;
              status_next   = ST_READ;
              is_empty_next = 1'b1;
            end else begin
              state_next = S_READ;
            end
          end else if (count == '0) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      // walk entries until one has lower end above v or none are left
      S_SCAN: begin
        if (lo_rd > v) begin
          next_lo_next = lo_rd;
          next_hi_next = hi_rd;
          state_next   = S_DECIDE;
        end else begin
          prev_hi_next = hi_rd;
          left_lo_next = lo_rd;
          pos_next     = pos + 1'b1;
          if (pos + 1'b1 == count) begin
            state_next = S_DECIDE;
          end else begin
            rd_addr = IW'(pos + 1'b1);
          end
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        if (covered) begin
          strobe_next = 1'b1;
          status_next = ST_COVERED;
        end else if (left_adj && right_adj) begin
          wr_en      = 1'b1;
          wr_addr    = IW'(pos - 1'b1);
          wr_lo      = left_lo;
          wr_hi      = next_hi;
          count_next = count - 1'b1;
          if (pos + 1'b1 < count) begin
            rd_addr    = IW'(pos + 1'b1);
            idx_next   = pos + 1'b1;
            state_next = S_SHDN;
          end else begin
            strobe_next = 1'b1;
            status_next = ST_MERGED;
          end
        end else if (left_adj) begin
          wr_en       = 1'b1;
          wr_addr     = IW'(pos - 1'b1);
          wr_lo       = left_lo;
          wr_hi       = v;
          strobe_next = 1'b1;
          status_next = ST_EXTENDED;
        end else if (right_adj) begin
          wr_en       = 1'b1;
          wr_lo       = v;
          wr_hi       = next_hi;
          strobe_next = 1'b1;
          status_next = ST_EXTENDED;
        end else if (count >= CW'(MAX_RANGES)) begin
          strobe_next = 1'b1;
          status_next = ST_FULL;
        end else if (pos == count) begin
          wr_en       = 1'b1;
          count_next  = count + 1'b1;
          strobe_next = 1'b1;
          status_next = ST_INSERTED;
        end else begin
          rd_addr    = IW'(count - 1'b1);
          idx_next   = count - 1'b1;
          state_next = S_SHUP;
        end
      end
      // move entries up from the top, then place v
      S_SHUP: begin
        wr_en   = 1'b1;
        wr_addr = IW'(idx + 1'b1);
        wr_lo   = lo_rd;
        wr_hi   = hi_rd;
        if (idx == pos) begin
          state_next = S_PLACE;
        end else begin
          rd_addr  = IW'(idx - 1'b1);
          idx_next = idx - 1'b1;
        end
      end
      S_PLACE: begin
        wr_en       = 1'b1;
        count_next  = count + 1'b1;
        strobe_next = 1'b1;
        status_next = ST_INSERTED;
        state_next  = S_IDLE;
      end
      // move entries above the merged one down by one
      S_SHDN: begin
        wr_en   = 1'b1;
        wr_addr = IW'(idx - 1'b1);
        wr_lo   = lo_rd;
        wr_hi   = hi_rd;
        if (idx == count) begin
          strobe_next = 1'b1;
          status_next = ST_MERGED;
          state_next  = S_IDLE;
        end else begin
          rd_addr  = IW'(idx + 1'b1);
          idx_next = idx + 1'b1;
        end
      end
      S_READ: begin
        strobe_next     = 1'b1;
        status_next     = ST_READ;
        range_low_next  = 16'(lo_rd);
        range_high_next = 16'(hi_rd);
        last_next       = (idx + 1'b1 == count);
        if (idx + 1'b1 == count) begin
          state_next = S_IDLE;
        end else begin
          rd_addr  = IW'(idx + 1'b1);
          idx_next = idx + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
    idx        <= idx_next;
    pos        <= pos_next;
    v          <= v_next;
    left_lo    <= left_lo_next;
    prev_hi    <= prev_hi_next;
    next_lo    <= next_lo_next;
    next_hi    <= next_hi_next;
    status     <= status_next;
    range_low  <= range_low_next;
    range_high <= range_high_next;
    is_empty   <= is_empty_next;
    last       <= last_next;
  end

  assign q_pop = (state == S_IDLE) && q_valid && !rst;

  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_RANGES))
    else $error("entry count above capacity");
  assert property (@(posedge clk) disable iff (rst) strobe && status == ST_READ && is_empty
                   |-> last)
    else $error("empty read not marked last");
  assert property (@(posedge clk) disable iff (rst)
                   strobe && status != ST_READ |-> last)
    else $error("add result not marked last");
endmodule

// ----- src/disjoint_interval_tracker.sv -----
// Top level of the disjoint interval tracker: command front end and table engine.
// Depends on dit_pkg, dit_front, dit_engine.
//
// Usage: raise start with cmd/value while busy is low; the word is taken at that edge.
// cmd add gives one result word with last set and a status code: covered, extended,
// merged, inserted or full (value dropped). cmd read gives one word per stored
// interval in ascending order, last set on the final one; an empty table gives
// one word with is_empty set. Each result word shows for one cycle with strobe.
// An add first scans the stored entries in order up to the first one whose lower
// end is above the value; an insert in the middle then moves each entry above that
// point up by one and places the value, and a merge moves each entry above the
// merged one down by one. A read gives its words one per cycle, in order, with
// no gaps between them.
// The table has one read and one write port: one entry is read or moved each cycle.
// A two-word queue sits in front of the engine, so busy rises only when it fills.
// Reset empties the table and the queue at once; no clearing pass is needed.
// The receiver cannot stall: strobe words must be captured when shown.
module disjoint_interval_tracker #(
  parameter int MAX_RANGES = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cmd,
  input  logic [15:0]       value,
  output logic              strobe,
  output logic [2:0]        status,
  output logic [15:0]       range_low,
  output logic [15:0]       range_high,
  output logic              is_empty,
  output logic              last
);
  import dit_pkg::*;

  logic                  q_valid, q_cmd, q_pop;
  logic [VALUE_BITS-1:0] q_value;
  status_t               status_e;

  dit_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .start, .cmd, .value, .busy,
    .q_valid, .q_cmd, .q_value, .q_pop
  );

  dit_engine #(.MAX_RANGES(MAX_RANGES), .VALUE_BITS(VALUE_BITS)) u_engine (
    .clk, .rst, .q_valid, .q_cmd, .q_value, .q_pop,
    .strobe, .status(status_e), .range_low, .range_high, .is_empty, .last
  );

  assign status = status_e;
endmodule

// ----- tb/tb_top.sv -----
// Testbench for disjoint_interval_tracker: drives add and read commands, predicts
// each result word from a local interval table and checks them in order.
// Depends on dit_pkg and the disjoint_interval_tracker RTL.
`timescale 1ns / 1ps

module tb_top;
  import dit_pkg::*;

  localparam int MAX_RANGES = 32;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    status_t     status;
    logic [15:0] range_low;
    logic [15:0] range_high;
    logic        is_empty;
    logic        last;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        cmd = CMD_ADD;
  logic [15:0] value = '0;
  logic        busy, strobe, is_empty, last;
  logic [2:0]  status;
  logic [15:0] range_low, range_high;

  // predicted table of intervals
  logic [15:0] lo_tab [MAX_RANGES];
  logic [15:0] hi_tab [MAX_RANGES];
  int          n_ranges = 0;

  result_word_t expected_words [$];
  int           idle_pct = 0;
  bit           failed = 1'b0;
  int           cycles = 0;

  disjoint_interval_tracker u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .value(value),
    .strobe(strobe), .status(status), .range_low(range_low),
    .range_high(range_high), .is_empty(is_empty), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout at %0t", $time);
      $display("** disjoint_interval_tracker: FAILED **");
      $finish;
    end
  end

  // predict the status of one add and update the table
  function automatic status_t predict_add(logic [15:0] v);
    int  i;
    bit  left_adj, right_adj;
    i = 0;
    while (i < n_ranges && lo_tab[i] <= v) i++;
    if (i > 0 && v <= hi_tab[i-1]) return ST_COVERED;
    left_adj  = (i > 0) && ({1'b0, hi_tab[i-1]} + 17'd1 == {1'b0, v});
    right_adj = (i < n_ranges) && ({1'b0, v} + 17'd1 == {1'b0, lo_tab[i]});
    if (left_adj && right_adj) begin
      hi_tab[i-1] = hi_tab[i];
      for (int j = i; j + 1 < n_ranges; j++) begin
        lo_tab[j] = lo_tab[j+1];
        hi_tab[j] = hi_tab[j+1];
      end
      n_ranges--;
      return ST_MERGED;
    end
    if (left_adj) begin
      hi_tab[i-1] = v;
      return ST_EXTENDED;
    end
    if (right_adj) begin
      lo_tab[i] = v;
      return ST_EXTENDED;
    end
    if (n_ranges >= MAX_RANGES) return ST_FULL;
    for (int j = n_ranges; j > i; j--) begin
      lo_tab[j] = lo_tab[j-1];
      hi_tab[j] = hi_tab[j-1];
    end
    lo_tab[i] = v;
    hi_tab[i] = v;
    n_ranges++;
    return ST_INSERTED;
  endfunction

  // queue the words one command should produce
  task automatic predict_command(logic c, logic [15:0] v);
    result_word_t w;
    w = '0;
    if (c == CMD_ADD) begin
      w.status = predict_add(v);
      w.last = 1'b1;
      expected_words.insert(expected_words.size(), w);
    end else if (n_ranges == 0) begin
      w.status = ST_READ;
      w.is_empty = 1'b1;
      w.last = 1'b1;
      expected_words.insert(expected_words.size(), w);
    end else begin
      for (int k = 0; k < n_ranges; k++) begin
        w.status = ST_READ;
        w.range_low = lo_tab[k];
        w.range_high = hi_tab[k];
        w.last = (k == n_ranges - 1);
        expected_words.insert(expected_words.size(), w);
      end
    end
  endtask

  // send one command word; start stays high across back-to-back words
  task automatic send_word(logic c, logic [15:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_command(c, v);
  endtask

  // result checker
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && strobe) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word status=%0d lo=%0d hi=%0d", $time, status,
                 range_low, range_high);
        failed = 1'b1;
      end else begin
        want = expected_words.pop_front();
        if (status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, status);
          failed = 1'b1;
        end
        if (range_low !== want.range_low) begin
          $display("%0t: range_low exp %0d got %0d", $time, want.range_low, range_low);
          failed = 1'b1;
        end
        if (range_high !== want.range_high) begin
          $display("%0t: range_high exp %0d got %0d", $time, want.range_high,
                   range_high);
          failed = 1'b1;
        end
        if (is_empty !== want.is_empty) begin
          $display("%0t: is_empty exp %0d got %0d", $time, want.is_empty, is_empty);
          failed = 1'b1;
        end
        if (last !== want.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, last);
          failed = 1'b1;
        end
      end
    end
  end

  // extremes, empty read, every add outcome except full, field bits
  task automatic test_directed();
    idle_pct = 0;
    send_word(CMD_READ, 16'hFFFF);
    send_word(CMD_ADD, 16'h0000);
    send_word(CMD_ADD, 16'hFFFF);
    send_word(CMD_ADD, 16'h0000);
    send_word(CMD_ADD, 16'h0001);
    send_word(CMD_ADD, 16'hFFFE);
    send_word(CMD_ADD, 16'h0003);
    send_word(CMD_ADD, 16'h0002);
    send_word(CMD_ADD, 16'h0006);
    send_word(CMD_ADD, 16'h0005);
    send_word(CMD_ADD, 16'hAAAA);
    send_word(CMD_ADD, 16'h5555);
    send_word(CMD_READ, 16'h0000);
  endtask

  // fill to capacity and hit full, extend and merge while full, then covered and insert
  task automatic test_full_table();
    for (int k = 0; k < 40; k++) send_word(CMD_ADD, 16'h1000 + 16'(4 * k));
    send_word(CMD_ADD, 16'h1001);
    send_word(CMD_ADD, 16'h1002);
    send_word(CMD_ADD, 16'h1003);
    send_word(CMD_ADD, 16'h1000);
    send_word(CMD_ADD, 16'h9000);
    send_word(CMD_READ, 16'h0000);
  endtask

  // random commands on a narrow window so neighbors meet often
  task automatic test_random(int pct, int count);
    logic [15:0] base;
    idle_pct = pct;
    base = 16'($urandom);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0) send_word(CMD_READ, 16'($urandom));
      else if ($urandom_range(9) == 0) send_word(CMD_ADD, 16'($urandom));
      else send_word(CMD_ADD, base + 16'($urandom_range(80)));
    end
    send_word(CMD_READ, 16'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(0, 10);
    test_random(58, 10);
    test_random(58, 10);
    test_random(32, 10);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (!failed && expected_words.size() == 0) begin
      $display("** disjoint_interval_tracker: PASSED **");
    end else begin
      $display("** disjoint_interval_tracker: FAILED **");
    end
    $finish;
  end
endmodule
